// ===== design/ipadt_pkg.sv =====
package ipadt_pkg;

	localparam int CAPACITY = 256;
	localparam int FLAG_W   = 8;
	localparam int KEY_W    = 32;
	localparam int MASK_W   = 8;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITELIST = 1'd0,
		REG_BLACKLIST = 1'd1
	} reg_idx_t;

	typedef struct packed {
		op_t               opcode;
		logic [KEY_W-1:0]  ip_address;
		logic [FLAG_W-1:0] flag_bits;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic              is_whitelisted;
		logic              is_blacklisted;
		logic [FLAG_W-1:0] flags_now;
	} rsp_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic              active;
		logic              found;
		logic              free_seen;
		logic [FLAG_W-1:0] flags;
	} tok_t;

	// Write-back broadcast to every cell
	typedef struct packed {
		logic              wr_hit;
		logic              wr_free;
		logic              valid;
		logic [FLAG_W-1:0] flags;
	} cmt_t;

endpackage

// ===== design/ipadt_cell.sv =====
module ipadt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ipadt_pkg::KEY_W-1:0] key,
	input  ipadt_pkg::tok_t           tok_in,
	input  ipadt_pkg::cmt_t           cmt,
	output ipadt_pkg::tok_t           tok_out
);
	import ipadt_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [FLAG_W-1:0] flags_q;
	logic              hit_mark_q;
	logic              free_mark_q;
	tok_t              tok_q;
	logic              hit;

	assign hit     = valid_q && (key_q == key);
	assign tok_out = tok_q;

	// token stage and the marks left behind by the passing search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			hit_mark_q  <= 1'b0;
			free_mark_q <= 1'b0;
		end else begin
			tok_q.active <= tok_in.active;
			if (tok_in.active) begin
				tok_q.found     <= tok_in.found | hit;
				tok_q.free_seen <= tok_in.free_seen | !valid_q;
				tok_q.flags     <= hit ? flags_q : tok_in.flags;
				hit_mark_q      <= hit;
				free_mark_q     <= !valid_q && !tok_in.free_seen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmt.wr_hit && hit_mark_q) begin
			valid_q <= cmt.valid;
		end else if (cmt.wr_free && free_mark_q) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmt.wr_hit && hit_mark_q) begin
			flags_q <= cmt.flags;
		end else if (cmt.wr_free && free_mark_q) begin
			flags_q <= cmt.flags;
			key_q   <= key;
		end
	end

endmodule

// ===== design/ip_allow_deny_table_top.sv =====
// Channel   Handshake                 Payload               Direction
// request   start & !busy             req   (req_t)         in
// result    done (one-cycle strobe)   rsp   (rsp_t)         out
// config    cfg_valid & cfg_ready     cfg_index, cfg_data   in
//
// After the accepting edge, go_q injects the search token, which walks the
// cell chain one cell per cycle; the write-back then registers the result
// and its strobe. A new item may be accepted in the cycle the result shows.
// Reset empties the table at once (valid bits only) and loads the masks.
// The result receiver cannot stall; done flags each result for one cycle only.
module ip_allow_deny_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  ipadt_pkg::req_t                 req,
	output logic                            done,
	output ipadt_pkg::rsp_t                 rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ipadt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipadt_pkg::MASK_W-1:0]    cfg_data
);
	import ipadt_pkg::*;

	logic              busy_q;
	logic              go_q;
	req_t              cmd_q;
	rsp_t              rsp_q;
	logic              done_q;
	logic [MASK_W-1:0] wl_mask_q;
	logic [MASK_W-1:0] bl_mask_q;

	tok_t              chain [CAPACITY+1];
	logic [CAPACITY:0] act_vec;
	tok_t              tail;
	cmt_t              cmt;
	rsp_t              rsp_d;
	logic [FLAG_W-1:0] new_flags;
	logic              accept;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// Inject a fresh token at the head of the chain for one cycle
	assign chain[0] = '{active: go_q, found: 1'b0, free_seen: 1'b0, flags: '0};
	assign tail     = chain[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ipadt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (cmd_q.ip_address),
			.tok_in  (chain[i]),
			.cmt     (cmt),
			.tok_out (chain[i+1])
		);
	end

	for (genvar i = 0; i <= CAPACITY; i++) begin : g_act
		assign act_vec[i] = chain[i].active;
	end

	// Decide the write-back and the result once the token leaves the last cell
	always_comb begin
		cmt       = '0;
		rsp_d     = '0;
		new_flags = '0;
		unique case (cmd_q.opcode)
			OP_INSERT: begin
				if (tail.found) begin
					new_flags   = tail.flags | cmd_q.flag_bits;
					cmt.wr_hit  = tail.active;
					cmt.valid   = 1'b1;
				end else if (tail.free_seen) begin
					new_flags   = cmd_q.flag_bits;
					cmt.wr_free = tail.active;
					cmt.valid   = 1'b1;
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			OP_DELETE: begin
				if (tail.found) begin
					new_flags  = tail.flags & ~cmd_q.flag_bits;
					cmt.wr_hit = tail.active;
					cmt.valid  = |new_flags;
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			OP_LOOKUP: begin
				if (tail.found) begin
					new_flags = tail.flags;
				end
			end
			default: begin
				new_flags = '0;
			end
		endcase
		cmt.flags            = new_flags;
		rsp_d.flags_now      = new_flags;
		rsp_d.is_whitelisted = |(new_flags & wl_mask_q);
		rsp_d.is_blacklisted = |(new_flags & bl_mask_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			go_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q   <= accept;
			done_q <= tail.active;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.active) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Hold the command for the whole sweep; capture the result at write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
		if (tail.active) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_mask_q <= MASK_W'(1);
			bl_mask_q <= MASK_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WHITELIST: wl_mask_q <= cfg_data;
				REG_BLACKLIST: bl_mask_q <= cfg_data;
				default:       wl_mask_q <= wl_mask_q;
			endcase
		end
	end

	// At most one search token is ever in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_vec))
		else $error("more than one search token in the chain");

	// A token exists only while an item is being served
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(act_vec != '0) |-> busy_q)
		else $error("search token while idle");

	// Every result follows the token leaving the last cell
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(tail.active))
		else $error("result without a finished search");

	// Full is reported only for an insert
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == ST_FULL) |-> (cmd_q.opcode == OP_INSERT))
		else $error("full status on a non-insert");

	// Write-back selects at most one kind of target
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmt.wr_hit && cmt.wr_free))
		else $error("write-back to both hit and free cells");

endmodule
